@@ hdl/mcfp_pkg.sv @@
// motor command frame parser: shared types, character codes and limits
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package mcfp_pkg;

    localparam int FRAME_LEN = 8;
    localparam int POS_W     = $clog2(FRAME_LEN);

    // slot layout of a frame
    localparam int SLOT_SPEED_HI  = 0;
    localparam int SLOT_SPEED_MID = 1;
    localparam int SLOT_SPEED_LO  = 2;
    localparam int SLOT_DC_DIR    = 3;
    localparam int SLOT_ANGLE_HI  = 4;
    localparam int SLOT_ANGLE_LO  = 5;
    localparam int SLOT_STEP_DIR  = 6;
    localparam int SLOT_END       = 7;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_FILL = 8'h37;
    localparam logic [7:0] CHAR_E    = 8'h45;
    localparam logic [7:0] CHAR_F    = 8'h46;
    localparam logic [7:0] CHAR_B    = 8'h42;
    localparam logic [7:0] CHAR_R    = 8'h52;
    localparam logic [7:0] CHAR_L    = 8'h4C;

    localparam logic [7:0] MAX_SPEED = 8'd100;
    localparam logic [7:0] MAX_ANGLE = 8'd45;

    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

    // stepper history kept between frames
    typedef struct packed {
        logic [5:0] angle;
        logic       went_right;
        logic       went_left;
    } steer_t;

    // one result item minus the echoed byte
    typedef struct packed {
        logic       done;
        logic       ok;
        logic [6:0] speed;
        logic       ccw;
        logic       right;
        logic [6:0] degrees;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/mcfp_assembler.sv @@
// frame assembler: slot position counter and the eight-byte frame store
// depends on mcfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcfp_assembler (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire logic [7:0]        rx_byte,
    output mcfp_pkg::frame_t       frame,
    output logic                   done
);

    logic [mcfp_pkg::POS_W-1:0] pos_reg;
    logic [mcfp_pkg::POS_W-1:0] pos_next;
    mcfp_pkg::frame_t           store_reg;
    mcfp_pkg::frame_t           store_next;

    // frame as it reads with the current byte already in its slot
    always_comb begin
        for (int i = 0; i < mcfp_pkg::FRAME_LEN; i++) begin
            frame[i] = (pos_reg == mcfp_pkg::POS_W'(i)) ? rx_byte : store_reg[i];
        end
    end

    assign done = (rx_byte == mcfp_pkg::CHAR_E) ||
                  (pos_reg == mcfp_pkg::POS_W'(mcfp_pkg::FRAME_LEN - 1));

    always_comb begin
        store_next = store_reg;
        pos_next   = pos_reg;
        if (advance) begin
            if (done) begin
                store_next = {mcfp_pkg::FRAME_LEN{mcfp_pkg::CHAR_FILL}};
                pos_next   = '0;
            end else begin
                store_next = frame;
                pos_next   = pos_reg + mcfp_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            store_reg <= {mcfp_pkg::FRAME_LEN{mcfp_pkg::CHAR_FILL}};
        end else begin
            pos_reg   <= pos_next;
            store_reg <= store_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/mcfp_decode.sv @@
// frame checker and stepper move calculation, purely combinational
// depends on mcfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcfp_decode (
    input  wire mcfp_pkg::frame_t frame,
    input  wire logic             done,
    input  wire mcfp_pkg::steer_t steer,
    output mcfp_pkg::result_t     result,
    output mcfp_pkg::steer_t      steer_next
);

    logic [7:0] s0, s1, s2, s3, s4, s5, s6, s7;
    logic [7:0] speed_mod;
    logic [7:0] angle_mod;
    logic [5:0] angle;
    logic       go_right;
    logic       same_way;
    logic       move_same;
    logic [6:0] degrees;
    logic       ok;

    assign s0 = frame[mcfp_pkg::SLOT_SPEED_HI];
    assign s1 = frame[mcfp_pkg::SLOT_SPEED_MID];
    assign s2 = frame[mcfp_pkg::SLOT_SPEED_LO];
    assign s3 = frame[mcfp_pkg::SLOT_DC_DIR];
    assign s4 = frame[mcfp_pkg::SLOT_ANGLE_HI];
    assign s5 = frame[mcfp_pkg::SLOT_ANGLE_LO];
    assign s6 = frame[mcfp_pkg::SLOT_STEP_DIR];
    assign s7 = frame[mcfp_pkg::SLOT_END];

    // digit sums wrap at 256, so 8-bit arithmetic is exact
    assign speed_mod = 8'(8'(8'(s0 - mcfp_pkg::CHAR_ZERO) * 8'd100)
                        + 8'(8'(s1 - mcfp_pkg::CHAR_ZERO) * 8'd10)
                        + 8'(s2 - mcfp_pkg::CHAR_ZERO));
    assign angle_mod = 8'(8'(8'(s4 - mcfp_pkg::CHAR_ZERO) * 8'd10)
                        + 8'(s5 - mcfp_pkg::CHAR_ZERO));
    assign angle     = angle_mod[5:0];

    assign ok = done
             && (s0 == mcfp_pkg::CHAR_ZERO || s0 == mcfp_pkg::CHAR_ONE)
             && (speed_mod <= mcfp_pkg::MAX_SPEED)
             && (s3 == mcfp_pkg::CHAR_F || s3 == mcfp_pkg::CHAR_B)
             && (angle_mod <= mcfp_pkg::MAX_ANGLE)
             && (s6 == mcfp_pkg::CHAR_R || s6 == mcfp_pkg::CHAR_L)
             && (s7 == mcfp_pkg::CHAR_E);

    assign go_right = (s6 == mcfp_pkg::CHAR_R);
    assign same_way = go_right ? steer.went_right : steer.went_left;

    // relative move from the previous absolute angle
    always_comb begin
        if (same_way) begin
            if (angle >= steer.angle) begin
                degrees   = 7'(angle - steer.angle);
                move_same = 1'b1;
            end else begin
                degrees   = 7'(steer.angle - angle);
                move_same = 1'b0;
            end
        end else begin
            degrees   = 7'(angle) + 7'(steer.angle);
            move_same = 1'b1;
        end
    end

    always_comb begin
        result      = '0;
        result.done = done;
        result.ok   = ok;
        steer_next  = steer;
        if (ok) begin
            result.speed   = speed_mod[6:0];
            result.ccw     = (s3 == mcfp_pkg::CHAR_F);
            result.right   = (move_same == go_right);
            result.degrees = degrees;
            steer_next.angle      = angle;
            steer_next.went_right = go_right;
            steer_next.went_left  = !go_right;
        end
    end

endmodule

`default_nettype wire

@@ hdl/motor_command_frame_parser.sv @@
// motor command frame parser: input register, frame assembly, check, result register
// depends on mcfp_pkg, mcfp_assembler, mcfp_decode
//
// usage
//   s_ channel: one received byte per transfer (s_rx_byte), valid/ready handshake.
//   m_ channel: exactly one result per byte: the echoed byte, frame_done when the
//   byte closed a frame ('E' or the eighth slot), frame_ok when that frame passed
//   its checks, and for a good frame the dc speed/direction and the relative
//   stepper move. all motor fields read zero otherwise.
//   path: an accepted byte moves into the input register, then through the check
//   logic into the result register, which drives m_.
//   throughput: one byte per cycle while m_ready is high; the frame and stepper
//   state update in the same cycle that the byte moves into the result register.
//   reset (aresetn low, synchronous): both stages empty, slot position 0, every
//   frame slot reads '7', stepper angle 0 and no previous direction.
//   stall: while m_ready is low the result holds; the input register still takes
//   one more byte, then s_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module motor_command_frame_parser (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_echo_byte,
    output logic            m_frame_done,
    output logic            m_frame_ok,
    output logic [6:0]      m_motor_speed,
    output logic            m_dc_counterclockwise,
    output logic            m_step_right,
    output logic [6:0]      m_step_degrees
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    logic [7:0]        echo_reg;
    mcfp_pkg::result_t result_reg;
    mcfp_pkg::steer_t  steer_reg;
    mcfp_pkg::steer_t  steer_next;
    mcfp_pkg::result_t result;
    mcfp_pkg::frame_t  frame;
    logic              done;
    logic              out_free;
    logic              advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    mcfp_assembler u_assembler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .frame   (frame),
        .done    (done)
    );

    mcfp_decode u_decode (
        .frame      (frame),
        .done       (done),
        .steer      (steer_reg),
        .result     (result),
        .steer_next (steer_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            steer_reg     <= '0;
        end else begin
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                steer_reg <= steer_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            echo_reg   <= in_byte_reg;
            result_reg <= result;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_echo_byte           = echo_reg;
    assign m_frame_done          = result_reg.done;
    assign m_frame_ok            = result_reg.ok;
    assign m_motor_speed         = result_reg.speed;
    assign m_dc_counterclockwise = result_reg.ccw;
    assign m_step_right          = result_reg.right;
    assign m_step_degrees        = result_reg.degrees;

    // a good frame is always a closed frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_frame_ok || m_frame_done))
        else $error("frame_ok without frame_done");

    // motor fields stay zero unless the frame passed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_ok) |-> (m_motor_speed == 7'd0 && m_step_degrees == 7'd0
            && !m_dc_counterclockwise && !m_step_right))
        else $error("motor fields set on a rejected byte");

    // accepted frames stay within speed and move limits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_ok) |-> (m_motor_speed <= 7'd100 && m_step_degrees <= 7'd90))
        else $error("speed or stepper move out of range");

    // stepper history only changes when a good frame moves to the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && result.ok) |=> $stable(steer_reg))
        else $error("stepper state changed without a good frame");

endmodule

`default_nettype wire

@@ dv/motor_command_frame_parser_tb.sv @@
// self-checking testbench for motor_command_frame_parser: queue-fed driver, checking monitor
// depends on mcfp_pkg and the motor_command_frame_parser rtl
`timescale 1ns / 1ps

module motor_command_frame_parser_tb;

    localparam int NUM_ITEMS    = 1700;
    localparam int QUIET_TAIL   = 150;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 60;
    localparam int WATCHDOG_MAX = 2000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0]        echo;
        mcfp_pkg::result_t res;
    } reply_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_echo_byte;
    logic       m_frame_done;
    logic       m_frame_ok;
    logic [6:0] m_motor_speed;
    logic       m_dc_counterclockwise;
    logic       m_step_right;
    logic [6:0] m_step_degrees;

    motor_command_frame_parser dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_rx_byte             (s_rx_byte),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_echo_byte           (m_echo_byte),
        .m_frame_done          (m_frame_done),
        .m_frame_ok            (m_frame_ok),
        .m_motor_speed         (m_motor_speed),
        .m_dc_counterclockwise (m_dc_counterclockwise),
        .m_step_right          (m_step_right),
        .m_step_degrees        (m_step_degrees)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [7:0] pending_bytes[$];
    reply_t     expected_replies[$];
    int         total_bytes;
    int         bytes_sent;
    int         replies_seen;
    int         mismatches;
    int         frames_closed;
    int         frames_good;
    int         stall_cycles;

    // parser state as predicted
    mcfp_pkg::frame_t rx_frame;
    logic [2:0]       rx_pos;
    logic [5:0]       cur_angle;
    logic             went_right;
    logic             went_left;

    function automatic int unsigned digit_val(input logic [7:0] c);
        return {24'd0, c} - 32'd48;
    endfunction

    function automatic reply_t parse_byte(input logic [7:0] b);
        reply_t      r;
        int unsigned sp;
        int unsigned ang;
        int unsigned prev;
        int unsigned deg;
        logic        done;
        logic        ok;
        logic        goes_right;
        logic        same;
        logic        fwd;
        r = '0;
        r.echo = b;
        rx_frame[rx_pos] = b;
        done = (b == mcfp_pkg::CHAR_E) || (rx_pos == 3'(mcfp_pkg::SLOT_END));
        ok = 1'b0;
        if (done) begin
            sp = (digit_val(rx_frame[mcfp_pkg::SLOT_SPEED_HI]) * 100
                  + digit_val(rx_frame[mcfp_pkg::SLOT_SPEED_MID]) * 10
                  + digit_val(rx_frame[mcfp_pkg::SLOT_SPEED_LO])) & 32'hFF;
            ang = (digit_val(rx_frame[mcfp_pkg::SLOT_ANGLE_HI]) * 10
                   + digit_val(rx_frame[mcfp_pkg::SLOT_ANGLE_LO])) & 32'hFF;
            ok = (rx_frame[mcfp_pkg::SLOT_SPEED_HI] == mcfp_pkg::CHAR_ZERO
                  || rx_frame[mcfp_pkg::SLOT_SPEED_HI] == mcfp_pkg::CHAR_ONE)
                 && sp <= mcfp_pkg::MAX_SPEED
                 && (rx_frame[mcfp_pkg::SLOT_DC_DIR] == mcfp_pkg::CHAR_F
                     || rx_frame[mcfp_pkg::SLOT_DC_DIR] == mcfp_pkg::CHAR_B)
                 && ang <= mcfp_pkg::MAX_ANGLE
                 && (rx_frame[mcfp_pkg::SLOT_STEP_DIR] == mcfp_pkg::CHAR_R
                     || rx_frame[mcfp_pkg::SLOT_STEP_DIR] == mcfp_pkg::CHAR_L)
                 && rx_frame[mcfp_pkg::SLOT_END] == mcfp_pkg::CHAR_E;
            if (ok) begin
                prev = cur_angle;
                goes_right = (rx_frame[mcfp_pkg::SLOT_STEP_DIR] == mcfp_pkg::CHAR_R);
                same = goes_right ? went_right : went_left;
                // same direction as last time: move by the difference
                if (same) begin
                    if (ang >= prev) begin
                        deg = ang - prev;
                        fwd = 1'b1;
                    end else begin
                        deg = prev - ang;
                        fwd = 1'b0;
                    end
                end else begin
                    deg = ang + prev;
                    fwd = 1'b1;
                end
                r.res.speed = sp[6:0];
                r.res.ccw = (rx_frame[mcfp_pkg::SLOT_DC_DIR] == mcfp_pkg::CHAR_F);
                r.res.right = (fwd == goes_right);
                r.res.degrees = deg[6:0];
                cur_angle = ang[5:0];
                went_right = goes_right;
                went_left = !goes_right;
            end
            rx_frame = {mcfp_pkg::FRAME_LEN{mcfp_pkg::CHAR_FILL}};
            rx_pos = '0;
        end else begin
            rx_pos = rx_pos + 3'd1;
        end
        r.res.done = done;
        r.res.ok = ok;
        return r;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            pending_bytes.push_back(s[i]);
        end
    endtask

    // mostly well-formed frames with random content, some corrupted, cut short or noise
    task automatic gen_frame();
        logic [7:0] f[mcfp_pkg::FRAME_LEN];
        int         sp;
        int         ang;
        int         kind;
        int         cut;
        sp = $urandom_range(0, 110);
        ang = $urandom_range(0, 49);
        f[mcfp_pkg::SLOT_SPEED_HI] = mcfp_pkg::CHAR_ZERO + 8'(sp / 100);
        f[mcfp_pkg::SLOT_SPEED_MID] = mcfp_pkg::CHAR_ZERO + 8'((sp / 10) % 10);
        f[mcfp_pkg::SLOT_SPEED_LO] = mcfp_pkg::CHAR_ZERO + 8'(sp % 10);
        if ($urandom_range(0, 19) == 0) begin
            f[mcfp_pkg::SLOT_SPEED_HI] = mcfp_pkg::CHAR_ZERO + 8'($urandom_range(2, 9));
        end
        f[mcfp_pkg::SLOT_DC_DIR] = $urandom_range(0, 1) ? mcfp_pkg::CHAR_F : mcfp_pkg::CHAR_B;
        f[mcfp_pkg::SLOT_ANGLE_HI] = mcfp_pkg::CHAR_ZERO + 8'(ang / 10);
        f[mcfp_pkg::SLOT_ANGLE_LO] = mcfp_pkg::CHAR_ZERO + 8'(ang % 10);
        f[mcfp_pkg::SLOT_STEP_DIR] = $urandom_range(0, 2) ? mcfp_pkg::CHAR_R : mcfp_pkg::CHAR_L;
        f[mcfp_pkg::SLOT_END] = mcfp_pkg::CHAR_E;
        kind = $urandom_range(0, 99);
        cut = mcfp_pkg::FRAME_LEN;
        if (kind < 70) begin
        end else if (kind < 82) begin
            f[$urandom_range(0, mcfp_pkg::FRAME_LEN - 1)] = 8'($urandom);
        end else if (kind < 90) begin
            // early end marker
            cut = $urandom_range(0, mcfp_pkg::FRAME_LEN - 2);
            f[cut] = mcfp_pkg::CHAR_E;
            cut = cut + 1;
        end else if (kind < 95) begin
            f[mcfp_pkg::SLOT_END] = 8'($urandom);
        end else begin
            cut = 0;
            repeat ($urandom_range(1, 10)) pending_bytes.push_back(8'($urandom));
        end
        for (int i = 0; i < cut; i++) begin
            pending_bytes.push_back(f[i]);
        end
    endtask

    // sender
    int   send_gap;
    logic rx_long_hold = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_replies.push_back(parse_byte(s_rx_byte));
                bytes_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!rx_long_hold && bytes_sent < total_bytes - QUIET_TAIL
                             && ((bytes_sent / 200) % 3) != 2
                             && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 8);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_rx_byte <= pending_bytes.pop_front();
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("result %0d: %s expected %0d, got %0d", replies_seen, name,
                         exp_v, act_v);
            end
        end
    endtask

    // receiver and checker
    int   stall_left;
    int   hold_left;
    logic hold_done;

    always @(posedge aclk) begin
        reply_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result, echo %0d", m_echo_byte);
                    end
                end else begin
                    e = expected_replies.pop_front();
                    check_field("echo_byte", e.echo, m_echo_byte);
                    check_field("frame_done", 8'(e.res.done), 8'(m_frame_done));
                    check_field("frame_ok", 8'(e.res.ok), 8'(m_frame_ok));
                    check_field("motor_speed", 8'(e.res.speed), 8'(m_motor_speed));
                    check_field("dc_counterclockwise", 8'(e.res.ccw),
                                8'(m_dc_counterclockwise));
                    check_field("step_right", 8'(e.res.right), 8'(m_step_right));
                    check_field("step_degrees", 8'(e.res.degrees), 8'(m_step_degrees));
                    frames_closed += e.res.done;
                    frames_good += e.res.ok;
                end
                replies_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_cycles++;
                m_ready <= 1'b0;
                rx_long_hold <= (hold_left > 0);
            end else if (!hold_done && replies_seen >= HOLD_AT) begin
                // long hold-off so the block backs up into its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                stall_cycles++;
                rx_long_hold <= 1'b1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                stall_cycles++;
                m_ready <= 1'b0;
            end else if (replies_seen < total_bytes - QUIET_TAIL
                         && ((replies_seen / 250) % 3) != 1
                         && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(0, 8);
                stall_cycles++;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    int idle_run;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
                if (idle_run >= WATCHDOG_MAX) begin
                    $display("timeout: no transfer for %0d cycles", idle_run);
                    $display("Verification failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        rx_frame = {mcfp_pkg::FRAME_LEN{mcfp_pkg::CHAR_FILL}};
        rx_pos = '0;
        cur_angle = '0;
        went_right = 1'b0;
        went_left = 1'b0;
        bytes_sent = 0;
        replies_seen = 0;
        mismatches = 0;
        frames_closed = 0;
        frames_good = 0;
        stall_cycles = 0;
        send_gap = 0;
        stall_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        idle_run = 0;

        // directed: extreme speed and angle, both directions, early end, extreme bytes
        push_text("100F45RE");
        push_text("000B00LE");
        push_text("E");
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        push_text("E");
        while (pending_bytes.size() < NUM_ITEMS) gen_frame();
        total_bytes = pending_bytes.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_sent < total_bytes || expected_replies.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);

        $display("sent %0d bytes, %0d frames closed of which %0d good", bytes_sent,
                 frames_closed, frames_good);
        $display("receiver stalled %0d cycles incl. one %0d-cycle hold; %0d mismatches",
                 stall_cycles, HOLD_CYCLES, mismatches);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
